@@ sv/running_range_normalizer_assert.svh @@
// ----------------------------------------------------------------------------
// running_range_normalizer_assert.svh
// assertion macros used by the normalizer checker
// ----------------------------------------------------------------------------
`ifndef RUNNING_RANGE_NORMALIZER_ASSERT_SVH
`define RUNNING_RANGE_NORMALIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RRN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RRN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rrn_pkg.sv @@
// ----------------------------------------------------------------------------
// rrn_pkg
// shared types, codes and widths of the running range normalizer
// ----------------------------------------------------------------------------
package rrn_pkg;

  // item field widths
  localparam int OP_W     = 2;
  localparam int CHAN_W   = 4;
  localparam int MV_W     = 15;
  localparam int BOUND_W  = 16;
  localparam int CFG_IDX_W = 1;

  // divider widths: magnitude of product and of bound span
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;

  // bound values after reset or a clear
  localparam logic signed [BOUND_W-1:0] LOW_RESET  = 16'sd11000;
  localparam logic signed [BOUND_W-1:0] HIGH_RESET = -16'sd11000;

  // input item kinds
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_FREEZE = 2'd2,
    OP_POLY   = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_MIN = 1'b0,
    CFG_OUT_MAX = 1'b1
  } cfg_reg_t;

endpackage

@@ sv/rrn_ram.sv @@
// ----------------------------------------------------------------------------
// rrn_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module rrn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rrn_div.sv @@
// ----------------------------------------------------------------------------
// rrn_div
// unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module rrn_div
  import rrn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int STEPS = DIV_NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;

  logic [DIV_NUM_W-1:0] step_num;
  logic [DIV_DEN_W-1:0] step_rem;
  logic [DIV_DEN_W:0]   step_sh;

  // two shift-subtract steps; quotient bits shift in behind the dividend
  always_comb begin
    step_num = num;
    step_rem = rem;
    step_sh  = '0;
    for (int s = 0; s < 2; s++) begin
      step_sh  = {step_rem, step_num[DIV_NUM_W-1]};
      step_num = {step_num[DIV_NUM_W-2:0], 1'b0};
      if (step_sh >= {1'b0, den}) begin
        step_sh     = step_sh - {1'b0, den};
        step_num[0] = 1'b1;
      end
      step_rem = step_sh[DIV_DEN_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      num <= step_num;
      rem <= step_rem;
    end
  end

  assign quotient = num;

endmodule

@@ sv/running_range_normalizer.sv @@
// ----------------------------------------------------------------------------
// running_range_normalizer
// per-sample running min/max tracking and linear rescale onto a set range
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per handshake: a sample (tdata) with opcode and
//   channel in tuser. sample items widen the bounds (unless frozen), then
//   produce one result on m_axis; clear, freeze and poly items only change
//   state and produce nothing. out_min/out_max are written on the cfg port.
// sequence
//   an event item is taken in idle and leaves the block ready for the next
//   item. a sample is followed by no other item until its result is loaded
//   into the output register; on the way it passes the bound memory read,
//   the write-back/multiply, the 2-bit-per-cycle divider and the add/clamp.
// reset
//   flags clear, out_min = 0, out_max = 10000, every bound entry reads as
//   11000/-11000 through per-entry valid bits; no clearing pass is needed.
// stall
//   a finished result sits in the output register; the next item is taken
//   meanwhile, and a second result waits in its final cycle until m_axis
//   has taken the first.
// ----------------------------------------------------------------------------
module running_range_normalizer
  import rrn_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [14:0] sample_mv, [15] zero
  input  logic [5:0]           s_axis_tuser,  // [1:0] opcode, [5:2] chan
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // [14:0] scaled_mv, [29:15] bound_low,
                                              // [44:30] bound_high, [47:45] zero
  output logic [5:0]           m_axis_tuser   // [3:0] out_chan, [4] frozen, [5] per_channel
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIVS = 6'b001000,
    S_DIVW = 6'b010000,
    S_FIX  = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic signed [MV_W-1:0] out_min, out_max;

  // mode flags and bound entry valid bits
  logic                freeze_flag, poly_flag;
  logic [CHANNELS-1:0] entry_vld;

  // item registers
  logic signed [MV_W-1:0] item_v;
  logic [CHAN_W-1:0]      item_chan;
  logic [AW-1:0]          item_addr;
  logic                   item_vld, item_frz, item_poly;

  // datapath registers
  logic signed [BOUND_W-1:0]   lo_q, hi_q;
  logic signed [BOUND_W:0]     diff_q, span_q;
  logic signed [BOUND_W-1:0]   orange_q;
  logic signed [DIV_NUM_W-1:0] prod_q, q_s;

  // input decode
  op_t           in_op;
  logic [CHAN_W-1:0] in_chan;
  logic          in_acc, chan_ok;
  logic [AW-1:0] rd_addr;

  assign in_op   = op_t'(s_axis_tuser[1:0]);
  assign in_chan = s_axis_tuser[5:2];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign chan_ok = ({1'b0, in_chan} < (CHAN_W + 1)'(CHANNELS));
  assign rd_addr = poly_flag ? in_chan[AW-1:0] : '0;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // bound memory: {high, low} per entry
  logic [2*BOUND_W-1:0] ram_rdata, ram_wdata;
  logic                 ram_we;

  rrn_ram #(
    .WIDTH (2 * BOUND_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_bounds (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // read-modify: entry not yet written reads as the cleared value
  logic signed [BOUND_W-1:0] lo_cur, hi_cur, lo_new, hi_new, v_ext;

  always_comb begin
    v_ext  = {item_v[MV_W-1], item_v};
    lo_cur = item_vld ? ram_rdata[BOUND_W-1:0]         : LOW_RESET;
    hi_cur = item_vld ? ram_rdata[2*BOUND_W-1:BOUND_W] : HIGH_RESET;
    lo_new = (!item_frz && (v_ext < lo_cur)) ? v_ext : lo_cur;
    hi_new = (!item_frz && (v_ext > hi_cur)) ? v_ext : hi_cur;
  end

  assign ram_we    = (state == S_READ);
  assign ram_wdata = {hi_new, lo_new};

  // multiply (sample - low) by output span
  logic signed [2*BOUND_W:0] prod_full;
  assign prod_full = diff_q * orange_q;

  // divider operands are magnitudes, sign restored afterwards
  logic [DIV_NUM_W-1:0] div_num, div_q;
  logic [BOUND_W:0]     span_abs;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done, q_neg, span_zero;

  assign div_num   = prod_q[DIV_NUM_W-1] ? DIV_NUM_W'(-prod_q) : DIV_NUM_W'(prod_q);
  assign span_abs  = span_q[BOUND_W] ? (BOUND_W + 1)'(-span_q) : (BOUND_W + 1)'(span_q);
  assign div_den   = span_abs[DIV_DEN_W-1:0];
  assign q_neg     = prod_q[DIV_NUM_W-1] ^ span_q[BOUND_W];
  assign span_zero = (span_q == '0);

  rrn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVS),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // offset by out_min and clamp: first to out_max, then to out_min
  logic signed [DIV_NUM_W:0] sum, omin_ext, omax_ext, clamp_hi, res;

  always_comb begin
    omin_ext = (DIV_NUM_W + 1)'(out_min);
    omax_ext = (DIV_NUM_W + 1)'(out_max);
    sum      = (out_min == out_max) ? '0 : omin_ext + (DIV_NUM_W + 1)'(q_s);
    clamp_hi = (sum > omax_ext) ? omax_ext : sum;
    res      = (clamp_hi < omin_ext) ? omin_ext : clamp_hi;
  end

  logic out_load;
  assign out_load = (state == S_FIX) && (!m_axis_tvalid || m_axis_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (in_op == OP_SAMPLE) && chan_ok) state_next = S_READ;
      end
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_DIVS;
      S_DIVS: state_next = S_DIVW;
      S_DIVW: begin
        if (div_done) state_next = S_FIX;
      end
      S_FIX: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      freeze_flag   <= 1'b0;
      poly_flag     <= 1'b0;
      entry_vld     <= '0;
      out_min       <= '0;
      out_max       <= 15'sd10000;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // config writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_OUT_MIN: out_min <= cfg_data;
          CFG_OUT_MAX: out_max <= cfg_data;
        endcase
      end
      // event items
      if (in_acc) begin
        unique case (in_op)
          OP_SAMPLE: ;
          OP_CLEAR:  entry_vld <= '0;
          OP_FREEZE: freeze_flag <= !freeze_flag;
          OP_POLY: begin
            poly_flag <= !poly_flag;
            entry_vld <= '0;
          end
        endcase
      end
      // write-back marks the entry valid
      if (ram_we) entry_vld[item_addr] <= 1'b1;
      // output register
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      item_v    <= s_axis_tdata[MV_W-1:0];
      item_chan <= in_chan;
      item_addr <= rd_addr;
      item_vld  <= entry_vld[rd_addr];
      item_frz  <= freeze_flag;
      item_poly <= poly_flag;
    end
    if (state == S_READ) begin
      lo_q     <= lo_new;
      hi_q     <= hi_new;
      diff_q   <= (BOUND_W + 1)'(v_ext) - (BOUND_W + 1)'(lo_new);
      span_q   <= (BOUND_W + 1)'(hi_new) - (BOUND_W + 1)'(lo_new);
      orange_q <= BOUND_W'(out_max) - BOUND_W'(out_min);
    end
    if (state == S_MUL) begin
      prod_q <= prod_full[DIV_NUM_W-1:0];
    end
    if ((state == S_DIVW) && div_done) begin
      q_s <= span_zero ? '0 : (q_neg ? DIV_NUM_W'(-div_q) : div_q);
    end
    if (out_load) begin
      m_axis_tdata <= {3'b000, hi_q[MV_W-1:0], lo_q[MV_W-1:0], res[MV_W-1:0]};
      m_axis_tuser <= {item_poly, item_frz, item_chan};
    end
  end

endmodule

@@ sv/rrn_checker.sv @@
// ----------------------------------------------------------------------------
// rrn_checker
// port-level checks of the running range normalizer, bound to the top level
// ----------------------------------------------------------------------------
`include "running_range_normalizer_assert.svh"

module rrn_checker
  import rrn_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [MV_W-1:0]      cfg_data,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [5:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [47:0]          m_axis_tdata,
  input logic [5:0]           m_axis_tuser
);

  // shadow of the output range written on the config port
  logic signed [MV_W-1:0] sh_min, sh_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_min <= '0;
      sh_max <= 15'sd10000;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_OUT_MIN) sh_min <= cfg_data;
      if (cfg_index == CFG_OUT_MAX) sh_max <= cfg_data;
    end
  end

  logic signed [MV_W-1:0] scaled, b_low, b_high;
  logic                   smp_acc;

  assign scaled  = m_axis_tdata[14:0];
  assign b_low   = m_axis_tdata[29:15];
  assign b_high  = m_axis_tdata[44:30];
  assign smp_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == OP_SAMPLE)
                   && ({1'b0, s_axis_tuser[5:2]} < (CHAN_W + 1)'(CHANNELS));

  // a stalled result holds
  `RRN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // tracked bounds enclose the sample, so they are ordered
  `RRN_ASSERT_NOW(a_bound_order, m_axis_tvalid && !m_axis_tuser[4],
    b_low <= b_high, "bounds inverted while tracking")

  // scaled value stays inside an ordered output range
  `RRN_ASSERT_NOW(a_clamp, m_axis_tvalid && (sh_min <= sh_max),
    (scaled >= sh_min) && (scaled <= sh_max), "scaled value outside output range")

  // a sample occupies the block after acceptance
  `RRN_ASSERT_NEXT(a_busy, smp_acc, !s_axis_tready, "input taken while a sample is in flight")

endmodule

bind running_range_normalizer rrn_checker #(.CHANNELS(CHANNELS)) u_rrn_checker (.*);
